// ===== rtl/heq_pkg.sv =====
// heq_pkg: shared types and constants for the histogram equalizer
// holds widths, item kinds, queue entry layout and the back-end state type
// no dependencies
package heq_pkg;

  localparam int unsigned NUM_LEVELS = 256;
  localparam int unsigned LVL_W      = 8;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned REM_W      = CNT_W + LVL_W;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W     = 2;
  localparam int unsigned QCNT_W     = 3;

  localparam logic [CNT_W-1:0] MAX_PIXELS = 25'd16777216;
  localparam logic [LVL_W-1:0] LAST_LEVEL = 8'd255;

  localparam logic RES_MAPPED = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  typedef enum logic [1:0] {
    KIND_COUNT,
    KIND_COUNT_LAST,
    KIND_MAP
  } item_kind_t;

  typedef struct packed {
    item_kind_t       kind;
    logic [LVL_W-1:0] pixel;
  } queue_entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_MAP_RD,
    ST_MAP_OUT,
    ST_BLD_RD,
    ST_BLD_ACC,
    ST_BLD_DIV,
    ST_REPORT
  } back_state_t;

endpackage

// ===== rtl/histogram_equalizer_int_unit.sv =====
// histogram_equalizer_int_unit: top level of the two-pass 8-bit histogram equalizer
// depends on heq_pkg, heq_front, heq_back (which uses heq_ram)
//
// Feed a frame with in_mode low to count it; the byte with in_last_pixel
// set ends the pass, builds the level map (cumulative count * 255 / total,
// truncated) and returns one report transfer with the frame's peak bin and
// an overflow flag when more than 16777216 bytes arrived. Then feed bytes
// with in_mode high: each returns one transfer with its equalized level.
// Mapping before the first build gives undefined levels. After reset the
// block zeroes the histogram ram with in_ready low. A small queue of four
// items decouples input from execution. The back end works one item at a
// time: a counted byte goes through queue pop, ram read and ram write-back
// of the incremented bin (both skipped once the count is full), a mapped
// byte through pop, map ram read and result load; the table build that
// follows a last byte reads, accumulates and divides each of the 256 bins
// with the 8-step shift-and-subtract divider, then loads the report.
module histogram_equalizer_int_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_mode,
  input  logic [7:0]  in_pixel_value,
  input  logic        in_last_pixel,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_result_kind,
  output logic [7:0]  out_mapped_value,
  output logic [24:0] out_peak_count,
  output logic        out_overflowed
);
  import heq_pkg::*;

  queue_entry_t deq_entry;
  logic         deq_valid;
  logic         deq_ready;
  logic         clearing;

  // front end: classify and queue incoming transfers
  heq_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_pixel_value (in_pixel_value),
    .in_last_pixel  (in_last_pixel),
    .clearing       (clearing),
    .deq_valid      (deq_valid),
    .deq_ready      (deq_ready),
    .deq_entry      (deq_entry)
  );

  // back end: histogram, table build and result register
  heq_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .deq_valid        (deq_valid),
    .deq_ready        (deq_ready),
    .deq_entry        (deq_entry),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_mapped_value (out_mapped_value),
    .out_peak_count   (out_peak_count),
    .out_overflowed   (out_overflowed)
  );

endmodule

// ===== rtl/heq_ram.sv =====
// heq_ram: generic single write port, single read port ram
// registered read data, updated only when a read is enabled
// no dependencies
module heq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/heq_front.sv =====
// heq_front: input side of the equalizer, classifies items and queues them
// depends on heq_pkg
module heq_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [7:0]           in_pixel_value,
  input  logic                 in_last_pixel,
  input  logic                 clearing,
  output logic                 deq_valid,
  input  logic                 deq_ready,
  output heq_pkg::queue_entry_t deq_entry
);
  import heq_pkg::*;

  queue_entry_t          q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;
  queue_entry_t          entry;
  logic                  push, pop;

  // classify on the way in
  always_comb begin
    entry.pixel = in_pixel_value;
    if (in_mode) begin
      entry.kind = KIND_MAP;
    end else if (in_last_pixel) begin
      entry.kind = KIND_COUNT_LAST;
    end else begin
      entry.kind = KIND_COUNT;
    end
  end

  assign in_ready  = (count_r != QCNT_W'(QUEUE_DEPTH)) && !clearing;
  assign deq_valid = (count_r != '0);
  assign deq_entry = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = deq_valid && deq_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry;
    end
  end

endmodule

// ===== rtl/heq_back.sv =====
// heq_back: execution side, counting, map lookup, table build and result register
// depends on heq_pkg and heq_ram
module heq_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  deq_valid,
  output logic                  deq_ready,
  input  heq_pkg::queue_entry_t deq_entry,
  output logic                  clearing,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_result_kind,
  output logic [7:0]            out_mapped_value,
  output logic [24:0]           out_peak_count,
  output logic                  out_overflowed
);
  import heq_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [LVL_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   cum_r, cum_nxt;
  logic [CNT_W-1:0]   peak_r, peak_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic               sat_r, sat_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [LVL_W-1:0]   quo_r, quo_nxt;
  logic [2:0]         bit_r, bit_nxt;
  queue_entry_t       item_r, item_nxt;

  logic               ov_r, ov_nxt;
  logic               ok_r, ok_nxt;
  logic [LVL_W-1:0]   om_r, om_nxt;
  logic [CNT_W-1:0]   op_r, op_nxt;
  logic               oo_r, oo_nxt;

  logic               slot_free;
  logic               is_full;
  logic               is_last;
  logic               div_ge;
  logic [REM_W-1:0]   trial;
  logic [CNT_W-1:0]   sum;

  logic               bin_we, bin_re;
  logic [LVL_W-1:0]   bin_waddr, bin_raddr;
  logic [CNT_W-1:0]   bin_wdata, bin_rdata;
  logic               map_we, map_re;
  logic [LVL_W-1:0]   map_waddr, map_raddr;
  logic [LVL_W-1:0]   map_wdata, map_rdata;

  heq_ram #(.WIDTH(CNT_W), .DEPTH(NUM_LEVELS)) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .re    (bin_re),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  heq_ram #(.WIDTH(LVL_W), .DEPTH(NUM_LEVELS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (map_re),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign slot_free = !ov_r || out_ready;
  assign is_full   = (total_r == MAX_PIXELS);
  assign is_last   = (item_r.kind == KIND_COUNT_LAST);
  assign trial     = REM_W'(total_r) << bit_r;
  assign div_ge    = (rem_r >= trial);
  assign sum       = cum_r + bin_rdata;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_LEVEL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (deq_valid) begin
          state_nxt = (deq_entry.kind == KIND_MAP) ? ST_MAP_RD : ST_CNT_RD;
        end
      end
      ST_CNT_RD: begin
        if (!is_full) begin
          state_nxt = ST_CNT_WR;
        end else begin
          state_nxt = is_last ? ST_BLD_RD : ST_IDLE;
        end
      end
      ST_CNT_WR:  state_nxt = is_last ? ST_BLD_RD : ST_IDLE;
      ST_MAP_RD:  state_nxt = ST_MAP_OUT;
      ST_MAP_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_BLD_RD:  state_nxt = ST_BLD_ACC;
      ST_BLD_ACC: state_nxt = ST_BLD_DIV;
      ST_BLD_DIV: begin
        if (bit_r == 3'd0) begin
          state_nxt = (idx_r == LAST_LEVEL) ? ST_REPORT : ST_BLD_RD;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // datapath and outputs
  always_comb begin
    idx_nxt   = idx_r;
    cum_nxt   = cum_r;
    peak_nxt  = peak_r;
    total_nxt = total_r;
    sat_nxt   = sat_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    bit_nxt   = bit_r;
    item_nxt  = item_r;
    ov_nxt    = ov_r && !out_ready;
    ok_nxt    = ok_r;
    om_nxt    = om_r;
    op_nxt    = op_r;
    oo_nxt    = oo_r;
    deq_ready = 1'b0;
    bin_we    = 1'b0;
    bin_waddr = idx_r;
    bin_wdata = '0;
    bin_re    = 1'b0;
    bin_raddr = idx_r;
    map_we    = 1'b0;
    map_waddr = idx_r;
    map_wdata = quo_r;
    map_re    = 1'b0;
    map_raddr = item_r.pixel;
    case (state_r)
      ST_CLEAR: begin
        bin_we  = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
      ST_IDLE: begin
        deq_ready = 1'b1;
        if (deq_valid) begin
          item_nxt = deq_entry;
        end
      end
      ST_CNT_RD: begin
        if (is_full) begin
          sat_nxt = 1'b1;
          idx_nxt = '0;
        end else begin
          bin_re    = 1'b1;
          bin_raddr = item_r.pixel;
        end
      end
      ST_CNT_WR: begin
        bin_we    = 1'b1;
        bin_waddr = item_r.pixel;
        bin_wdata = bin_rdata + 1'b1;
        total_nxt = total_r + 1'b1;
        idx_nxt   = '0;
      end
      ST_MAP_RD: begin
        map_re = 1'b1;
      end
      ST_MAP_OUT: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ok_nxt = RES_MAPPED;
          om_nxt = map_rdata;
          op_nxt = '0;
          oo_nxt = 1'b0;
        end
      end
      ST_BLD_RD: begin
        bin_re = 1'b1;
      end
      ST_BLD_ACC: begin
        if (bin_rdata > peak_r) begin
          peak_nxt = bin_rdata;
        end
        cum_nxt = sum;
        bin_we  = 1'b1;
        // cum * 255 as a shift and subtract
        rem_nxt = {sum, {LVL_W{1'b0}}} - REM_W'(sum);
        quo_nxt = '0;
        bit_nxt = 3'd7;
      end
      ST_BLD_DIV: begin
        if (div_ge) begin
          rem_nxt = rem_r - trial;
          quo_nxt = quo_r | (LVL_W'(1) << bit_r);
        end
        bit_nxt = bit_r - 1'b1;
        if (bit_r == 3'd0) begin
          map_we    = 1'b1;
          map_wdata = div_ge ? (quo_r | LVL_W'(1)) : quo_r;
          idx_nxt   = idx_r + 1'b1;
        end
      end
      ST_REPORT: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ok_nxt    = RES_REPORT;
          om_nxt    = '0;
          op_nxt    = peak_r;
          oo_nxt    = sat_r;
          total_nxt = '0;
          sat_nxt   = 1'b0;
          peak_nxt  = '0;
          cum_nxt   = '0;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      idx_r   <= '0;
      cum_r   <= '0;
      peak_r  <= '0;
      total_r <= '0;
      sat_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      cum_r   <= cum_nxt;
      peak_r  <= peak_nxt;
      total_r <= total_nxt;
      sat_r   <= sat_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    bit_r  <= bit_nxt;
    item_r <= item_nxt;
    ok_r   <= ok_nxt;
    om_r   <= om_nxt;
    op_r   <= op_nxt;
    oo_r   <= oo_nxt;
  end

  assign clearing         = (state_r == ST_CLEAR);
  assign out_valid        = ov_r;
  assign out_result_kind  = ok_r;
  assign out_mapped_value = om_r;
  assign out_peak_count   = op_r;
  assign out_overflowed   = oo_r;

endmodule

// ===== rtl/heq_checker.sv =====
// heq_checker: port-level assertions for histogram_equalizer_int_unit
// depends on heq_pkg; bound to the top level below
module heq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_mode,
  input logic [7:0]  in_pixel_value,
  input logic        in_last_pixel,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_result_kind,
  input logic [7:0]  out_mapped_value,
  input logic [24:0] out_peak_count,
  input logic        out_overflowed
);
  import heq_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mapped_value)
      && $stable(out_peak_count) && $stable(out_result_kind))
    else $error("stalled result changed");

  // in_ready is low as the clearing pass starts after reset
  a_clear: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_REPORT |->
      out_mapped_value == '0 && out_peak_count <= MAX_PIXELS)
    else $error("bad report fields");

  a_mapped_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RES_MAPPED |->
      out_peak_count == '0 && !out_overflowed)
    else $error("bad mapped pixel fields");

endmodule

bind histogram_equalizer_int_unit heq_checker u_heq_checker (.*);
